@@ sv/icu_pkg.sv @@
// ----------------------------------------------------------------------------
// icu_pkg
// Shared constants, types and arithmetic for the block cipher unit.
// ----------------------------------------------------------------------------
`default_nettype none

package icu_pkg;

  localparam int IcuMaxRounds = 16;

  // configuration register indexes
  localparam logic [1:0] CfgKeyHigh    = 2'd0;
  localparam logic [1:0] CfgKeyLow     = 2'd1;
  localparam logic [1:0] CfgKeyBytes   = 2'd2;
  localparam logic [1:0] CfgRoundCount = 2'd3;

  localparam int KeyBytesMax   = 16;
  localparam int DefaultRounds = 8;

  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [63:0] blk;
  } icu_pipe_t;

  typedef logic [5:0][15:0] icu_sk6_t;

  typedef enum logic [2:0] {
    KS_IDLE,
    KS_INIT,
    KS_FETCH,
    KS_CALC,
    KS_POW
  } icu_ks_state_e;

  // multiplication modulo 65537, zero stands for 65536
  function automatic logic [15:0] icu_mul(input logic [15:0] a, input logic [15:0] b);
    logic [31:0] p;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] res;
    p  = 32'(a) * 32'(b);
    lo = p[15:0];
    hi = p[31:16];
    if (a == 16'd0) begin
      res = 16'd1 - b;
    end else if (b == 16'd0) begin
      res = 16'd1 - a;
    end else begin
      res = lo - hi + ((lo < hi) ? 16'd1 : 16'd0);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ sv/idea_block_cipher_unit.sv @@
// ----------------------------------------------------------------------------
// idea_block_cipher_unit
// 64-bit block cipher with 128-bit key, rounds unrolled into a pipeline.
// ----------------------------------------------------------------------------
// every block passes through all MaxRounds rounds and the output register to done_o
// throughput: one block per cycle while busy is low; three register stages per round
// after reset and after every register write busy stays high while the
// sequencer rebuilds the inverse subkeys for the rounds in use
// done_o is a single-cycle strobe; the receiver cannot stall
`default_nettype none

module idea_block_cipher_unit import icu_pkg::*; #(
  parameter int MaxRounds = IcuMaxRounds
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        kind_i,
  input  wire logic [63:0] block_in_i,
  output logic             done_o,
  output logic [63:0]      block_out_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i
);

  localparam int SkDepth = 6 * MaxRounds + 4;
  localparam int RW      = $clog2(MaxRounds + 1);

  logic [63:0]   key_high_q, key_low_q;
  logic [4:0]    key_bytes_q, round_count_q;
  logic [RW-1:0] rounds;
  logic [15:0]   fwd [SkDepth];
  logic [15:0]   inv [SkDepth];
  icu_pipe_t     pipe [MaxRounds+1];
  logic [3:0][15:0] ok;
  logic [63:0]   out_d;
  logic          out_v_q;
  logic [63:0]   out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q    <= '0;
      key_low_q     <= '0;
      key_bytes_q   <= 5'(KeyBytesMax);
      round_count_q <= 5'(DefaultRounds);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgKeyHigh:    key_high_q    <= cfg_data_i;
        CfgKeyLow:     key_low_q     <= cfg_data_i;
        CfgKeyBytes:   key_bytes_q   <= cfg_data_i[4:0];
        CfgRoundCount: round_count_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // zero means the standard count, then saturate at the pipeline depth
  always_comb begin
    logic [5:0] rr;
    rr = (round_count_q == 5'd0) ? 6'(DefaultRounds) : 6'(round_count_q);
    if (rr > 6'(MaxRounds)) begin
      rr = 6'(MaxRounds);
    end
    rounds = RW'(rr);
  end

  icu_keysched #(.MaxRounds(MaxRounds)) u_keysched (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rebuild_i   (cfg_we_i),
    .key_high_i  (key_high_q),
    .key_low_i   (key_low_q),
    .key_bytes_i (key_bytes_q),
    .rounds_i    (rounds),
    .fwd_o       (fwd),
    .inv_o       (inv),
    .busy_o      (busy)
  );

  assign pipe[0] = '{valid: start && !busy, kind: kind_i, blk: block_in_i};

  for (genvar n = 0; n < MaxRounds; n++) begin : g_round
    icu_sk6_t fk, ik;
    for (genvar p = 0; p < 6; p++) begin : g_sk
      assign fk[p] = fwd[6*n+p];
      assign ik[p] = inv[6*n+p];
    end
    icu_round u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .act_i  (RW'(n) < rounds),
      .pipe_i (pipe[n]),
      .fk_i   (fk),
      .ik_i   (ik),
      .pipe_o (pipe[n+1])
    );
  end

  // output transform subkeys sit right after the last active round
  always_comb begin
    ok = '0;
    for (int rr = 1; rr <= MaxRounds; rr++) begin
      if (rounds == RW'(rr)) begin
        for (int p = 0; p < 4; p++) begin
          ok[p] = pipe[MaxRounds].kind ? inv[6*rr+p] : fwd[6*rr+p];
        end
      end
    end
  end

  assign out_d = {icu_mul(pipe[MaxRounds].blk[63:48], ok[0]),
                  pipe[MaxRounds].blk[31:16] + ok[1],
                  pipe[MaxRounds].blk[47:32] + ok[2],
                  icu_mul(pipe[MaxRounds].blk[15:0], ok[3])};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= pipe[MaxRounds].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o      = out_v_q;
  assign block_out_o = out_q;

endmodule

`default_nettype wire

@@ sv/icu_round.sv @@
// ----------------------------------------------------------------------------
// icu_round
// One cipher round as three register stages; passes data through when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module icu_round import icu_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      act_i,
  input  wire icu_pipe_t pipe_i,
  input  wire icu_sk6_t  fk_i,
  input  wire icu_sk6_t  ik_i,
  output icu_pipe_t      pipe_o
);

  icu_sk6_t    ka, kb, kc;
  logic        a_v_q, b_v_q, c_v_q;
  logic        a_k_q, b_k_q, c_k_q;
  logic [15:0] a_x0_q, a_x1_q, a_x2_q, a_x3_q;
  logic [15:0] b_x0_q, b_x1_q, b_x2_q, b_x3_q, b_t0_q;
  logic [63:0] c_blk_q;
  logic [15:0] a_x0_d, a_x1_d, a_x2_d, a_x3_d, b_t0_d;
  logic [15:0] t1, t0b;
  logic [63:0] c_blk_d;

  assign ka = pipe_i.kind ? ik_i : fk_i;
  assign kb = a_k_q ? ik_i : fk_i;
  assign kc = b_k_q ? ik_i : fk_i;

  always_comb begin
    a_x0_d = pipe_i.blk[63:48];
    a_x1_d = pipe_i.blk[47:32];
    a_x2_d = pipe_i.blk[31:16];
    a_x3_d = pipe_i.blk[15:0];
    if (act_i) begin
      a_x0_d = icu_mul(pipe_i.blk[63:48], ka[0]);
      a_x1_d = pipe_i.blk[47:32] + ka[1];
      a_x2_d = pipe_i.blk[31:16] + ka[2];
      a_x3_d = icu_mul(pipe_i.blk[15:0], ka[3]);
    end
  end

  assign b_t0_d = icu_mul(a_x0_q ^ a_x2_q, kb[4]);

  always_comb begin
    t1      = icu_mul(b_t0_q + (b_x1_q ^ b_x3_q), kc[5]);
    t0b     = b_t0_q + t1;
    c_blk_d = {b_x0_q, b_x1_q, b_x2_q, b_x3_q};
    if (act_i) begin
      c_blk_d = {b_x0_q ^ t1, b_x2_q ^ t1, t0b ^ b_x1_q, b_x3_q ^ t0b};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      a_v_q <= pipe_i.valid;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_k_q   <= pipe_i.kind;
    a_x0_q  <= a_x0_d;
    a_x1_q  <= a_x1_d;
    a_x2_q  <= a_x2_d;
    a_x3_q  <= a_x3_d;
    b_k_q   <= a_k_q;
    b_x0_q  <= a_x0_q;
    b_x1_q  <= a_x1_q;
    b_x2_q  <= a_x2_q;
    b_x3_q  <= a_x3_q;
    b_t0_q  <= b_t0_d;
    c_k_q   <= b_k_q;
    c_blk_q <= c_blk_d;
  end

  assign pipe_o = '{valid: c_v_q, kind: c_k_q, blk: c_blk_q};

endmodule

`default_nettype wire

@@ sv/icu_keysched.sv @@
// ----------------------------------------------------------------------------
// icu_keysched
// Forward subkeys by key rotation; inverse subkeys rebuilt by a sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module icu_keysched import icu_pkg::*; #(
  parameter int MaxRounds = IcuMaxRounds,
  localparam int SkDepth = 6 * MaxRounds + 4,
  localparam int SkW     = $clog2(SkDepth),
  localparam int RW      = $clog2(MaxRounds + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          rebuild_i,
  input  wire logic [63:0]   key_high_i,
  input  wire logic [63:0]   key_low_i,
  input  wire logic [4:0]    key_bytes_i,
  input  wire logic [RW-1:0] rounds_i,
  output logic [15:0]        fwd_o [SkDepth],
  output logic [15:0]        inv_o [SkDepth],
  output logic               busy_o
);

  logic [127:0]   key_raw, key_m;
  logic [4:0]     nbytes;
  icu_ks_state_e  state_q, state_d;
  logic [SkW-1:0] e_q, e_d, base_q, base_d, src;
  logic [RW-1:0]  i_q, i_d;
  logic [2:0]     p_q, p_d;
  logic [4:0]     cnt_q, cnt_d;
  logic [15:0]    x_q, x_d, y_q, y_d, y_step;
  logic           we;
  logic [15:0]    wdata;
  logic [15:0]    inv_q [SkDepth];
  logic           mulpos, last_grp, advance;

  assign key_raw = {key_high_i, key_low_i};
  assign nbytes  = (key_bytes_i > 5'(KeyBytesMax)) ? 5'(KeyBytesMax) : key_bytes_i;

  always_comb begin
    for (int b = 0; b < 16; b++) begin
      key_m[127-8*b -: 8] = (5'(b) < nbytes) ? key_raw[127-8*b -: 8] : 8'd0;
    end
  end

  // subkey g is word g%8 of the key rotated left by 25 per group of eight
  for (genvar g = 0; g < SkDepth; g++) begin : g_fwd
    localparam int Rot = (25 * (g / 8)) % 128;
    logic [255:0] dbl;
    logic [127:0] rot;
    assign dbl      = {key_m, key_m};
    assign rot      = dbl[255-Rot -: 128];
    assign fwd_o[g] = rot[127-16*(g%8) -: 16];
  end

  assign mulpos   = (p_q == 3'd0) || (p_q == 3'd3);
  assign last_grp = (i_q == rounds_i);

  always_comb begin
    src = base_q + SkW'(p_q);
    if ((p_q == 3'd4) || (p_q == 3'd5)) begin
      src = base_q - SkW'(6) + SkW'(p_q);
    end else if ((i_q != '0) && !last_grp && (p_q == 3'd1)) begin
      src = base_q + SkW'(2);
    end else if ((i_q != '0) && !last_grp && (p_q == 3'd2)) begin
      src = base_q + SkW'(1);
    end
  end

  assign y_step = cnt_q[0] ? icu_mul(y_q, x_q) : icu_mul(y_q, y_q);

  always_comb begin
    state_d = state_q;
    e_d     = e_q;
    base_d  = base_q;
    i_d     = i_q;
    p_d     = p_q;
    cnt_d   = cnt_q;
    x_d     = x_q;
    y_d     = y_q;
    we      = 1'b0;
    wdata   = x_q;
    advance = 1'b0;
    case (state_q)
      KS_IDLE: begin
      end
      KS_INIT: begin
        e_d     = '0;
        i_d     = '0;
        p_d     = '0;
        base_d  = SkW'(rounds_i) * SkW'(6);
        state_d = KS_FETCH;
      end
      KS_FETCH: begin
        x_d     = fwd_o[src];
        y_d     = fwd_o[src];
        state_d = KS_CALC;
      end
      KS_CALC: begin
        if (mulpos) begin
          cnt_d   = '0;
          state_d = KS_POW;
        end else begin
          we      = 1'b1;
          wdata   = ((p_q == 3'd1) || (p_q == 3'd2)) ? (16'd0 - x_q) : x_q;
          advance = 1'b1;
        end
      end
      KS_POW: begin
        // x^65535 as fifteen square and multiply pairs
        y_d   = y_step;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd29) begin
          we      = 1'b1;
          wdata   = y_step;
          advance = 1'b1;
        end
      end
      default: state_d = KS_INIT;
    endcase
    if (advance) begin
      e_d     = e_q + SkW'(1);
      state_d = KS_FETCH;
      if (last_grp && (p_q == 3'd3)) begin
        state_d = KS_IDLE;
      end else if (p_q == 3'd5) begin
        i_d    = i_q + RW'(1);
        p_d    = '0;
        base_d = base_q - SkW'(6);
      end else begin
        p_d = p_q + 3'd1;
      end
    end
    if (rebuild_i) begin
      state_d = KS_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= KS_INIT;
      e_q     <= '0;
      base_q  <= '0;
      i_q     <= '0;
      p_q     <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      e_q     <= e_d;
      base_q  <= base_d;
      i_q     <= i_d;
      p_q     <= p_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    if (we) begin
      inv_q[e_q] <= wdata;
    end
  end

  assign inv_o  = inv_q;
  assign busy_o = (state_q != KS_IDLE);

endmodule

`default_nettype wire

@@ sv/icu_checker.sv @@
// ----------------------------------------------------------------------------
// icu_checker
// Port-level timing checks for the block cipher unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module icu_checker import icu_pkg::*; #(
  parameter int MaxRounds = IcuMaxRounds,
  localparam int Latency = 3 * MaxRounds + 1
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic cfg_we_i,
  input wire logic done_o
);

  // every transaction comes back after the fixed pipeline latency
  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency done_o)
    else $error("accepted transaction did not complete on time");

  // no strobe without a matching transaction
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Latency))
    else $error("result strobe without a transaction");

  // a register write starts a subkey rebuild
  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy)
    else $error("busy not raised after register write");

endmodule

bind idea_block_cipher_unit icu_checker #(.MaxRounds(MaxRounds)) u_icu_checker (.*);

`default_nettype wire

@@ test/idea_block_cipher_unit_test.sv @@
// ----------------------------------------------------------------------------
// idea_block_cipher_unit_test
// Drives 64-bit blocks through the cipher unit under many key and round
// settings. A scoreboard recomputes every block from its own key schedule
// and compares each strobed result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module idea_block_cipher_unit_test;
  import icu_pkg::*;

  class cipher_scoreboard;
    logic [63:0] key_hi, key_lo;
    logic [4:0]  nbytes, rcount;
    logic [15:0] fwd_keys[100];
    logic [15:0] inv_keys[100];
    logic [63:0] expected_blocks[$];
    int          errors;

    function new();
      key_hi = '0; key_lo = '0; nbytes = 5'd16; rcount = 5'd8;
      errors = 0;
      rebuild();
    endfunction

    task report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function int rounds();
      int r;
      r = rcount;
      if (r == 0) r = 8;
      if (r > IcuMaxRounds) r = IcuMaxRounds;
      return r;
    endfunction

    function logic [15:0] mulm(input logic [15:0] a, input logic [15:0] b);
      logic [31:0] p;
      logic [15:0] lo, hi;
      if (a == 0) return 16'd1 - b;
      if (b == 0) return 16'd1 - a;
      p  = {16'd0, a} * {16'd0, b};
      lo = p[15:0];
      hi = p[31:16];
      return lo - hi + ((lo < hi) ? 16'd1 : 16'd0);
    endfunction

    function logic [15:0] minv(input logic [15:0] x);
      logic [15:0] y;
      y = x;
      for (int n = 0; n < 15; n++) begin
        y = mulm(y, y);
        y = mulm(y, x);
      end
      return y;
    endfunction

    function void rebuild();
      logic [7:0]  kb[16];
      int          r, nb, total, s, sw, base;
      logic [15:0] hi, lo;
      r = rounds();
      nb = (nbytes > 16) ? 16 : nbytes;
      total = 6 * r + 4;
      for (int b = 0; b < 8; b++) begin
        kb[b]     = key_hi[63 - 8*b -: 8];
        kb[b + 8] = key_lo[63 - 8*b -: 8];
      end
      for (int b = nb; b < 16; b++) kb[b] = 8'd0;
      for (int i = 0; i < 100; i++) begin
        fwd_keys[i] = '0;
        inv_keys[i] = '0;
      end
      for (int i = 0; i < 8; i++) fwd_keys[i] = {kb[2*i], kb[2*i+1]};
      // 25-bit rotation of the previous eight subkeys
      for (int i = 8; i < total; i++) begin
        base = (i & ~7) - 8;
        hi = fwd_keys[base + ((i + 1) & 7)];
        lo = fwd_keys[base + ((i + 2) & 7)];
        fwd_keys[i] = {hi[6:0], lo[15:7]};
      end
      for (int i = 0; i < r; i++) begin
        s = (r - i) * 6;
        sw = (i > 0) ? 1 : 0;
        inv_keys[i*6]     = minv(fwd_keys[s]);
        inv_keys[i*6 + 1] = -fwd_keys[s + 1 + sw];
        inv_keys[i*6 + 2] = -fwd_keys[s + 2 - sw];
        inv_keys[i*6 + 3] = minv(fwd_keys[s + 3]);
        inv_keys[i*6 + 4] = fwd_keys[(r - 1 - i)*6 + 4];
        inv_keys[i*6 + 5] = fwd_keys[(r - 1 - i)*6 + 5];
      end
      inv_keys[r*6]     = minv(fwd_keys[0]);
      inv_keys[r*6 + 1] = -fwd_keys[1];
      inv_keys[r*6 + 2] = -fwd_keys[2];
      inv_keys[r*6 + 3] = minv(fwd_keys[3]);
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [63:0] data);
      case (idx)
        CfgKeyHigh:    key_hi = data;
        CfgKeyLow:     key_lo = data;
        CfgKeyBytes:   nbytes = data[4:0];
        CfgRoundCount: rcount = data[4:0];
        default: ;
      endcase
      rebuild();
    endfunction

    function logic [63:0] cipher(input logic kind, input logic [63:0] blk);
      logic [15:0] k[100];
      logic [15:0] x0, x1, x2, x3, t0, t1;
      int i;
      for (int j = 0; j < 100; j++) k[j] = kind ? inv_keys[j] : fwd_keys[j];
      {x0, x1, x2, x3} = blk;
      i = 0;
      for (int n = 0; n < rounds(); n++) begin
        x0 = mulm(x0, k[i]);
        x1 = x1 + k[i+1];
        x2 = x2 + k[i+2];
        x3 = mulm(x3, k[i+3]);
        t0 = mulm(x0 ^ x2, k[i+4]);
        t1 = mulm(t0 + (x1 ^ x3), k[i+5]);
        t0 = t0 + t1;
        x0 = x0 ^ t1;
        x3 = x3 ^ t0;
        t0 = t0 ^ x1;
        x1 = x2 ^ t1;
        x2 = t0;
        i += 6;
      end
      x0 = mulm(x0, k[i]);
      x2 = x2 + k[i+1];
      x1 = x1 + k[i+2];
      x3 = mulm(x3, k[i+3]);
      return {x0, x2, x1, x3};
    endfunction

    function void note_input(input logic kind, input logic [63:0] blk);
      expected_blocks.push_back(cipher(kind, blk));
    endfunction

    task check_result(input logic [63:0] got);
      logic [63:0] want;
      if (expected_blocks.size() == 0) begin
        report($sformatf("unexpected block_out %h", got));
      end else begin
        want = expected_blocks.pop_front();
        if (got !== want) report($sformatf("block_out %h, want %h", got, want));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        kind_i;
  logic [63:0] block_in_i;
  logic        done_o;
  logic [63:0] block_out_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [63:0] cfg_data_i;

  cipher_scoreboard sb = new();
  int sender_idle_pct;

  idea_block_cipher_unit dut (
    .clk_i, .rst_ni, .start, .busy, .kind_i, .block_in_i,
    .done_o, .block_out_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(block_out_o);
  end

  task automatic send_block(input logic kind, input logic [63:0] blk);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start      <= 1'b1;
    kind_i     <= kind;
    block_in_i <= blk;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    sb.note_input(kind, blk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.expected_blocks.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [63:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, data);
    repeat (2) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_block();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return {4{16'h0001}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] small_field(input int lo, input int hi);
    // random upper bits so every data bit toggles
    return {$urandom, $urandom} & ~64'h1f | 64'($urandom_range(hi, lo));
  endfunction

  initial begin
    int nseg;
    rst_ni <= 1'b0;
    start <= 1'b0; kind_i <= 1'b0; block_in_i <= '0;
    cfg_we_i <= 1'b0; cfg_idx_i <= CfgKeyHigh; cfg_data_i <= '0;
    sender_idle_pct = 9;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset key: all zero, 16 bytes, 8 rounds
    send_block(1'b0, '0);
    send_block(1'b1, '0);
    send_block(1'b0, '1);
    send_block(1'b1, '1);
    send_block(1'b0, 64'h0001_0002_0003_0004);
    send_block(1'b1, 64'h8000_0000_0000_0001);
    drain();
    write_cfg(CfgKeyHigh, 64'h0001_0002_0003_0004);
    write_cfg(CfgKeyLow, 64'h0005_0006_0007_0008);
    send_block(1'b0, 64'h0000_0001_0002_0003);
    send_block(1'b1, 64'h11fb_ed2b_0198_6de5);
    drain();
    write_cfg(CfgKeyHigh, '1);
    write_cfg(CfgKeyLow, '1);
    send_block(1'b0, '1);
    send_block(1'b1, 64'h5555_aaaa_5555_aaaa);
    drain();
    // zero round count means eight, excess saturates
    write_cfg(CfgRoundCount, 64'd0);
    send_block(1'b0, rand_block());
    drain();
    write_cfg(CfgRoundCount, 64'd31);
    send_block(1'b1, rand_block());
    drain();
    write_cfg(CfgRoundCount, 64'd1);
    send_block(1'b0, rand_block());
    send_block(1'b1, rand_block());
    drain();
    // short, odd and excess key lengths
    write_cfg(CfgKeyBytes, 64'd0);
    send_block(1'b0, rand_block());
    drain();
    write_cfg(CfgKeyBytes, 64'd7);
    send_block(1'b1, rand_block());
    drain();
    write_cfg(CfgKeyBytes, 64'hffff_ffff_ffff_ffff);
    send_block(1'b0, rand_block());
    drain();

    nseg = 18;
    for (int seg = 0; seg < nseg; seg++) begin
      sender_idle_pct = (seg < nseg / 3) ? 9 : (seg < 2 * nseg / 3) ? 58 : 0;
      drain();
      write_cfg(CfgKeyHigh, ($urandom_range(5) == 0) ? '0 : {$urandom, $urandom});
      write_cfg(CfgKeyLow, ($urandom_range(5) == 0) ? '1 : {$urandom, $urandom});
      write_cfg(CfgKeyBytes, ($urandom_range(2) == 0) ? small_field(0, 31) : small_field(16, 16));
      write_cfg(CfgRoundCount, ($urandom_range(3) == 0) ? small_field(0, 31) : small_field(1, 16));
      for (int n = 0; n < 103; n++) send_block(1'($urandom), rand_block());
    end
    drain();
    if (sb.expected_blocks.size() != 0) sb.report("blocks never returned");
    if (sb.errors == 0) begin
      $display("idea_block_cipher_unit test passed");
    end else begin
      $display("idea_block_cipher_unit test failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("idea_block_cipher_unit test failed");
    $finish;
  end

endmodule

`default_nettype wire
